[hdl/pga_pkg.sv]
// Package for the page-group bump allocator.
// Holds the request, response and table entry types, status codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps

package pga_pkg;

	localparam logic [12:0] CNT_MAX = 13'd8191;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [24:0] alloc_size;
		logic [31:0] free_address;
		logic [31:0] new_pages_base;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic [12:0] pages_taken;
		logic [31:0] release_base;
		logic [12:0] release_pages;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ptr;
		logic [12:0] pages;
		logic [12:0] allocs;
	} entry_t;

	typedef struct packed {
		logic        alloc_hit;
		logic        free_hit;
		logic        release_all;
		logic [31:0] first_page;
		entry_t      alloc_upd;
		entry_t      free_upd;
	} eval_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_NEW,
		S_FETCH,
		S_MOVE
	} state_t;

endpackage

[hdl/pga_mem.sv]
// Group table storage: one write port, one read port with registered data.
// Depends on pga_pkg for the entry type.
`timescale 1ns / 1ps

module pga_mem
	import pga_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/pga_unit.sv]
// Shared entry evaluation unit: first-fit test, address match and entry updates.
// Depends on pga_pkg; used once per scanned table entry.
`timescale 1ns / 1ps

module pga_unit
	import pga_pkg::*;
#(
	parameter int PAGE_BYTES = 4096
) (
	input  entry_t      ent,
	input  logic [24:0] size,
	input  logic [31:0] addr,
	output eval_t       ev
);

	localparam int          SHIFT = $clog2(PAGE_BYTES);
	localparam logic [31:0] MASK  = 32'(PAGE_BYTES - 1);

	logic [SHIFT-1:0] off;
	logic [SHIFT:0]   fill;
	logic [31:0]      last_page;
	logic [31:0]      first_page;
	logic [12:0]      dec;

	always_comb begin
		off        = ent.ptr[SHIFT-1:0];
		fill       = {1'b0, off} + {1'b0, size[SHIFT-1:0]};
		last_page  = (ent.ptr - 32'd1) & ~MASK;
		first_page = last_page - ((32'(ent.pages) - 32'd1) << SHIFT);
		dec        = (ent.allocs == 13'd0) ? 13'd0 : ent.allocs - 13'd1;

		ev.alloc_hit   = (off != '0) && (ent.allocs != CNT_MAX)
			&& (fill <= (SHIFT+1)'(PAGE_BYTES));
		ev.free_hit    = ((addr & ~MASK) == last_page) || (addr == first_page);
		ev.release_all = (dec == 13'd0);
		ev.first_page  = first_page;

		ev.alloc_upd.ptr    = ent.ptr + 32'(size);
		ev.alloc_upd.pages  = ent.pages;
		ev.alloc_upd.allocs = ent.allocs + 13'd1;

		ev.free_upd.ptr    = ent.ptr;
		ev.free_upd.pages  = ent.pages;
		ev.free_upd.allocs = dec;
	end

endmodule

[hdl/page_group_bump_allocator.sv]
// Page-group bump allocator top level: sequencer, request registers and table.
// Depends on pga_pkg, pga_mem and pga_unit.
//
// Usage:
//   Drive req and raise start; the request is taken at a clock edge where start
//   is high and busy is low. busy is high while the sequencer is out of S_IDLE.
//   Exactly one response appears on rsp with done high for one cycle; the
//   receiver cannot hold it off and must take it in that cycle.
// Sequence:
//   Table full or free on an empty table: response in the cycle after accept.
//   Large allocate (a page or more): goes to S_NEW, which opens a new group.
//   Small allocate and free: when groups are live, the group table is scanned
//   in order, one entry per cycle through the table memory's single read port,
//   and the scan stops at the first matching entry or at the last live group.
//   A small allocate on an empty table, or one that misses, goes on to S_NEW
//   to open a new group; a free that drops a group to zero passes through
//   S_FETCH and S_MOVE to move the last entry into its slot.
// Throughput: one request at a time; next start is taken the cycle done is
//   high. Sustained rate is set by the scan length.
// Reset: arst_n clears the group count and sequencer; the table contents are
//   not cleared and need no clearing pass. PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps

module page_group_bump_allocator
	import pga_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int          AW    = $clog2(TABLE_DEPTH);
	localparam int          CW    = $clog2(TABLE_DEPTH + 1);
	localparam int          SHIFT = $clog2(PAGE_BYTES);
	localparam logic [31:0] MASK  = 32'(PAGE_BYTES - 1);

	state_t state_q, state_d;

	logic        type_q;
	logic [24:0] size_q;
	logic [31:0] addr_q;
	logic [31:0] base_q;

	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] chk_idx_q;
	logic [AW-1:0] hit_idx_q;
	logic [31:0]   rel_base_q;
	logic [12:0]   rel_pages_q;
	rsp_t          rsp_q;
	logic          done_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;
	eval_t         ev;

	logic        accept;
	logic [24:0] in_size;
	logic [25:0] np_sum;
	logic [25:0] np_full;
	logic [31:0] base_al;
	logic        last_chk;

	logic  latch_req, scan_start, scan_adv, cnt_inc, cnt_dec, rel_latch;
	logic  done_d;
	rsp_t  rsp_d;

	pga_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pga_unit #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_unit (
		.ent (mem_rdata),
		.size(size_q),
		.addr(addr_q),
		.ev  (ev)
	);

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign in_size = (req.alloc_size == 25'd0) ? 25'd1 : req.alloc_size;
	assign np_sum  = {1'b0, size_q} + 26'(PAGE_BYTES - 1);
	assign np_full = np_sum >> SHIFT;
	assign base_al = base_q & ~MASK;
	assign last_chk = (CW'(chk_idx_q) == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = chk_idx_q;
		mem_wdata  = ev.alloc_upd;
		mem_re     = 1'b0;
		mem_raddr  = rd_idx_q;
		latch_req  = 1'b0;
		scan_start = 1'b0;
		scan_adv   = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		rel_latch  = 1'b0;
		done_d     = 1'b0;
		rsp_d      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					latch_req = 1'b1;
					if (req.req_type == REQ_ALLOC) begin
						if (count_q == CW'(TABLE_DEPTH)) begin
							done_d       = 1'b1;
							rsp_d.status = ST_FAIL;
						end else if ((32'(in_size) < 32'(PAGE_BYTES)) && (count_q != '0)) begin
							scan_start = 1'b1;
							mem_re     = 1'b1;
							mem_raddr  = '0;
							state_d    = S_SCAN;
						end else begin
							state_d = S_NEW;
						end
					end else begin
						if (count_q == '0) begin
							done_d       = 1'b1;
							rsp_d.status = ST_MISS;
						end else begin
							scan_start = 1'b1;
							mem_re     = 1'b1;
							mem_raddr  = '0;
							state_d    = S_SCAN;
						end
					end
				end
			end
			S_SCAN: begin
				if ((type_q == REQ_ALLOC) && ev.alloc_hit) begin
					mem_we               = 1'b1;
					mem_wdata            = ev.alloc_upd;
					done_d               = 1'b1;
					rsp_d.status         = ST_OK;
					rsp_d.result_address = mem_rdata.ptr;
					state_d              = S_IDLE;
				end else if ((type_q == REQ_FREE) && ev.free_hit) begin
					if (ev.release_all) begin
						rel_latch = 1'b1;
						cnt_dec   = 1'b1;
						state_d   = S_FETCH;
					end else begin
						mem_we       = 1'b1;
						mem_wdata    = ev.free_upd;
						done_d       = 1'b1;
						rsp_d.status = ST_OK;
						state_d      = S_IDLE;
					end
				end else if (last_chk) begin
					if (type_q == REQ_ALLOC) begin
						state_d = S_NEW;
					end else begin
						done_d       = 1'b1;
						rsp_d.status = ST_MISS;
						state_d      = S_IDLE;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = rd_idx_q;
					scan_adv  = 1'b1;
				end
			end
			S_NEW: begin
				done_d = 1'b1;
				if (np_full > 26'(CNT_MAX)) begin
					rsp_d.status = ST_FAIL;
				end else begin
					mem_we               = 1'b1;
					mem_waddr            = count_q[AW-1:0];
					mem_wdata.ptr        = base_al + 32'(size_q);
					mem_wdata.pages      = np_full[12:0];
					mem_wdata.allocs     = 13'd1;
					cnt_inc              = 1'b1;
					rsp_d.status         = ST_OK;
					rsp_d.result_address = base_al;
					rsp_d.pages_taken    = np_full[12:0];
				end
				state_d = S_IDLE;
			end
			S_FETCH: begin
				mem_re    = 1'b1;
				mem_raddr = count_q[AW-1:0];
				state_d   = S_MOVE;
			end
			S_MOVE: begin
				mem_we              = 1'b1;
				mem_waddr           = hit_idx_q;
				mem_wdata           = mem_rdata;
				done_d              = 1'b1;
				rsp_d.status        = ST_OK;
				rsp_d.release_base  = rel_base_q;
				rsp_d.release_pages = rel_pages_q;
				state_d             = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= done_d;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (latch_req) begin
			type_q <= req.req_type;
			size_q <= in_size;
			addr_q <= req.free_address;
			base_q <= req.new_pages_base;
		end
		if (scan_start) begin
			rd_idx_q  <= AW'(1);
			chk_idx_q <= '0;
		end else if (scan_adv) begin
			rd_idx_q  <= rd_idx_q + AW'(1);
			chk_idx_q <= rd_idx_q;
		end
		if (rel_latch) begin
			hit_idx_q   <= chk_idx_q;
			rel_base_q  <= ev.first_page;
			rel_pages_q <= mem_rdata.pages;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[hdl/pga_chk.sv]
// Port-level checker for the page-group bump allocator, bound to the top level.
// Depends on pga_pkg for the response and status definitions.
`timescale 1ns / 1ps

module pga_chk
	import pga_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response shown while busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither busy nor answered");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a response");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("response without a request");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_OK)) |->
			((rsp.result_address == 32'd0) && (rsp.pages_taken == 13'd0)
			&& (rsp.release_pages == 13'd0)))
		else $error("failed request returned nonzero fields");

endmodule

bind page_group_bump_allocator pga_chk u_pga_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

[tb/sv/pga_group_checker.sv]
// Checker for the page-group bump allocator: watches the request and result channels,
// predicts each result from its own copy of the group table and compares field by field.
// Depends on pga_pkg.
`timescale 1ns / 1ps

module pga_group_checker
	import pga_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_total,
	output int   outstanding
);

	localparam logic [31:0] PAGE_SZ = 32'(PAGE_BYTES);

	logic [31:0] grp_ptr    [TABLE_DEPTH];
	logic [12:0] grp_pages  [TABLE_DEPTH];
	logic [12:0] grp_allocs [TABLE_DEPTH];
	int          live_count;
	rsp_t        pending_rsp[$];
	int          fail_count;

	function automatic logic [31:0] last_page(input logic [31:0] bump);
		logic [31:0] off;
		off = bump % PAGE_SZ;
		return (off == 32'd0) ? bump - PAGE_SZ : bump - off;
	endfunction

	function automatic rsp_t predict_group_op(input req_t r);
		rsp_t        o;
		logic [31:0] size;
		logic [31:0] base;
		logic [31:0] np;
		logic [31:0] off;
		logic [31:0] lastp;
		logic [31:0] firstp;
		logic [31:0] span;
		int          i;
		o = '0;
		o.status = ST_OK;
		if (r.req_type == REQ_ALLOC) begin
			size = 32'(r.alloc_size);
			if (size == 32'd0)
				size = 32'd1;
			if (live_count >= TABLE_DEPTH) begin
				o.status = ST_FAIL;
				return o;
			end
			if (size < PAGE_SZ) begin
				for (i = 0; i < live_count; i++) begin
					off = grp_ptr[i] % PAGE_SZ;
					if (off != 32'd0 && grp_allocs[i] < CNT_MAX && size <= PAGE_SZ - off) begin
						o.result_address = grp_ptr[i];
						grp_ptr[i] = grp_ptr[i] + size;
						grp_allocs[i] = grp_allocs[i] + 13'd1;
						return o;
					end
				end
			end
			np = (size + PAGE_SZ - 32'd1) / PAGE_SZ;
			if (np > 32'(CNT_MAX)) begin
				o.status = ST_FAIL;
				return o;
			end
			base = r.new_pages_base - r.new_pages_base % PAGE_SZ;
			grp_ptr[live_count] = base + size;
			grp_pages[live_count] = np[12:0];
			grp_allocs[live_count] = 13'd1;
			live_count++;
			o.result_address = base;
			o.pages_taken = np[12:0];
		end else begin
			for (i = 0; i < live_count; i++) begin
				lastp = last_page(grp_ptr[i]);
				span = 32'(grp_pages[i]) - 32'd1;
				firstp = lastp - span * PAGE_SZ;
				if (r.free_address - lastp < PAGE_SZ || r.free_address == firstp) begin
					if (grp_allocs[i] != 13'd0)
						grp_allocs[i] = grp_allocs[i] - 13'd1;
					if (grp_allocs[i] == 13'd0) begin
						o.release_base = firstp;
						o.release_pages = grp_pages[i];
						live_count--;
						grp_ptr[i] = grp_ptr[live_count];
						grp_pages[i] = grp_pages[live_count];
						grp_allocs[i] = grp_allocs[live_count];
					end
					return o;
				end
			end
			o.status = ST_MISS;
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s got %0h want %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			live_count = 0;
			fail_count = 0;
			pending_rsp.delete();
		end else begin
			if (done === 1'b1) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("result with no request waiting, address",
						rsp.result_address, 32'd0);
				end else begin
					want = pending_rsp.pop_front();
					check_field("status", 32'(rsp.status), 32'(want.status));
					check_field("result_address", rsp.result_address, want.result_address);
					check_field("pages_taken", 32'(rsp.pages_taken), 32'(want.pages_taken));
					check_field("release_base", rsp.release_base, want.release_base);
					check_field("release_pages", 32'(rsp.release_pages),
						32'(want.release_pages));
				end
			end
			if (start && !busy)
				pending_rsp.push_back(predict_group_op(req));
		end
		fail_total <= fail_count;
		outstanding <= pending_rsp.size();
	end

endmodule

[tb/sv/tb_page_group_bump_allocator.sv]
// Testbench top for the page-group bump allocator: clock, reset and request stimulus.
// Instantiates the block and pga_group_checker, and prints the verdict.
// Depends on pga_pkg, page_group_bump_allocator and pga_group_checker.
`timescale 1ns / 1ps

module tb_page_group_bump_allocator;
	import pga_pkg::*;

	localparam int TABLE_DEPTH    = 1024;
	localparam int PAGE_BYTES     = 4096;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;

	logic clk;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int   fail_total;
	int   outstanding;

	int          live_groups  = 0;
	int          quiet_cycles = 0;
	int          idle_pct     = 0;
	logic [31:0] addr_pool[$];
	logic        inflight_type[$];

	page_group_bump_allocator #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAGE_BYTES (PAGE_BYTES)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	pga_group_checker #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PAGE_BYTES (PAGE_BYTES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.fail_total (fail_total),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// track live groups and returned addresses for shaping frees; guard against hangs
	always @(negedge clk) begin
		logic kind;
		if (arst_n) begin
			if (done === 1'b1) begin
				kind = REQ_FREE;
				if (inflight_type.size() != 0)
					kind = inflight_type.pop_front();
				if (kind == REQ_ALLOC && rsp.status == ST_OK) begin
					addr_pool.push_back(rsp.result_address);
					if (rsp.pages_taken != 13'd0)
						live_groups++;
				end
				if (rsp.release_pages != 13'd0)
					live_groups--;
			end
			if (start && !busy)
				inflight_type.push_back(req.req_type);
			if (done === 1'b1 || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("page_group_bump_allocator: mismatch");
				$finish;
			end
		end
	end

	task automatic issue(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	function automatic req_t mk_req(input logic kind, input logic [24:0] size,
			input logic [31:0] addr, input logic [31:0] base);
		req_t r;
		r.req_type = kind;
		r.alloc_size = size;
		r.free_address = addr;
		r.new_pages_base = base;
		return r;
	endfunction

	function automatic req_t noise_req();
		req_t r;
		r.req_type = 1'($urandom);
		r.alloc_size = 25'($urandom);
		if ($urandom_range(0, 7) == 0)
			r.alloc_size = 25'($urandom_range(33550337, 33554431));
		r.free_address = $urandom;
		r.new_pages_base = $urandom;
		return r;
	endfunction

	function automatic logic [31:0] pick_base();
		if ($urandom_range(0, 3) == 0)
			return (32'($urandom_range(0, 15)) << 12) | 32'($urandom_range(0, 4095));
		return $urandom;
	endfunction

	function automatic req_t small_alloc();
		req_t r;
		r = noise_req();
		r.req_type = REQ_ALLOC;
		r.new_pages_base = pick_base();
		case ($urandom_range(0, 7))
			0: r.alloc_size = 25'd0;
			1: r.alloc_size = 25'd1;
			2: r.alloc_size = 25'd4095;
			3: r.alloc_size = 25'($urandom_range(1, 4095));
			default: r.alloc_size = 25'($urandom_range(1, 300));
		endcase
		return r;
	endfunction

	function automatic req_t large_alloc(input int top);
		req_t r;
		r = noise_req();
		r.req_type = REQ_ALLOC;
		r.new_pages_base = pick_base();
		r.alloc_size = 25'($urandom_range(PAGE_BYTES, top));
		return r;
	endfunction

	function automatic req_t free_known();
		req_t r;
		int   idx;
		r = noise_req();
		r.req_type = REQ_FREE;
		if (addr_pool.size() != 0) begin
			idx = $urandom_range(0, addr_pool.size() - 1);
			r.free_address = addr_pool[idx];
			addr_pool.delete(idx);
		end
		return r;
	endfunction

	initial begin
		req_t directed[$];
		int   n;
		int   pick;

		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'h0000_0000, 32'h0000_0000));
		directed.push_back(mk_req(REQ_ALLOC, 25'd0, 32'h0000_0000, 32'h0000_1234));
		directed.push_back(mk_req(REQ_ALLOC, 25'd1, 32'h0000_0000, 32'h0000_9000));
		directed.push_back(mk_req(REQ_ALLOC, 25'd4094, 32'h0000_0000, 32'h0000_9000));
		directed.push_back(mk_req(REQ_ALLOC, 25'd1, 32'h0000_0000, 32'h0000_9000));
		directed.push_back(mk_req(REQ_ALLOC, 25'd4095, 32'h0000_0000, 32'hFFFF_FFFF));
		directed.push_back(mk_req(REQ_ALLOC, 25'd4096, 32'h0000_0000, 32'hFFFF_FFFF));
		directed.push_back(mk_req(REQ_ALLOC, 25'd4097, 32'h0000_0000, 32'h0004_0000));
		directed.push_back(mk_req(REQ_ALLOC, 25'd33550336, 32'h0000_0000, 32'h1000_0000));
		directed.push_back(mk_req(REQ_ALLOC, 25'd33550337, 32'h0000_0000, 32'h1000_0000));
		directed.push_back(mk_req(REQ_ALLOC, 25'h1FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed.push_back(mk_req(REQ_ALLOC, 25'h100_0000, 32'h0000_0000, 32'h2000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'h0004_0000, 32'h0000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'h5A5A_5000, 32'h0000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'h0000_1000, 32'h0000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'h0000_1001, 32'h0000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'h0000_1FFF, 32'h0000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'd0, 32'hFFFF_F800, 32'h0000_0000));
		directed.push_back(mk_req(REQ_FREE, 25'h1FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed.push_back(mk_req(REQ_ALLOC, 25'h0FFF, 32'hFFFF_FFFF, 32'h0000_0000));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		foreach (directed[k])
			issue(directed[k]);

		// mixed traffic with few live groups
		for (n = 0; n < 130; n++) begin
			if (n % 30 == 0)
				idle_pct = ($urandom_range(0, 1) != 0) ? 35 : 0;
			pick = $urandom_range(0, 99);
			if (pick < 40)
				issue(small_alloc());
			else if (pick < 55)
				issue(large_alloc(65536));
			else if (pick < 90)
				issue(free_known());
			else
				issue(noise_req());
		end

		// fill the table, mostly with fresh groups
		n = 0;
		while (live_groups < TABLE_DEPTH && n < 1400) begin
			idle_pct = (live_groups < TABLE_DEPTH / 2) ? 20 : 0;
			pick = $urandom_range(0, 99);
			if (pick < 88)
				issue(large_alloc(12000));
			else if (pick < 94)
				issue(small_alloc());
			else
				issue(free_known());
			n++;
		end

		// hold the table at full
		idle_pct = 0;
		for (n = 0; n < 20; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				issue(large_alloc(12000));
			else if (pick < 60)
				issue(small_alloc());
			else if (pick < 90)
				issue(free_known());
			else
				issue(noise_req());
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_total == 0 && outstanding == 0)
			$display("page_group_bump_allocator: match");
		else
			$display("page_group_bump_allocator: mismatch");
		$finish;
	end

endmodule
